/* design/eru_pkg.sv */
// ----------------------------------------------------------------------------
// Enigma rotor unit package
// Shared constants, codes and the command and status types that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package eru_pkg;

	// Size of the wiring table and number of notch comparators.
	localparam int ALPHABET_MAX = 26;
	localparam int MAX_NOTCHES  = 2;

	// Field widths.
	localparam int FUNC_W   = 3;
	localparam int LETTER_W = 5;
	localparam int COUNT_W  = 2;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	// The working register holds a letter plus an offset, so it is one bit wider.
	localparam int R_W   = LETTER_W + 1;
	localparam int IDX_W = (ALPHABET_MAX > 1) ? $clog2(ALPHABET_MAX) : 1;

	// Only two notch registers exist, whatever the comparator count.
	localparam int NOTCH_LIM = (MAX_NOTCHES < 2) ? MAX_NOTCHES : 2;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_FORWARD  = 3'd0,
		FUNC_BACKWARD = 3'd1,
		FUNC_STEP     = 3'd2,
		FUNC_LOAD     = 3'd3,
		FUNC_SET_POS  = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		REG_ALPHABET_SIZE = 2'd0,
		REG_NOTCH_COUNT   = 2'd1,
		REG_NOTCH_FIRST   = 2'd2,
		REG_NOTCH_SECOND  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		SRC_POS,
		SRC_POS_INC,
		SRC_LETTER_PLUS_R,
		SRC_LETTER,
		SRC_RDATA,
		SRC_HIT
	} r_src_t;

	typedef enum logic [1:0] {
		RES_MAPPED,
		RES_MISS,
		RES_PLAIN,
		RES_STEP
	} res_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_P_RED,
		ST_T_RED,
		ST_F_RD,
		ST_F_LD,
		ST_F_RED,
		ST_SCAN,
		ST_S_RED,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [LETTER_W-1:0] alphabet_size;
		logic [COUNT_W-1:0]  notch_count;
		logic [LETTER_W-1:0] notch_first;
		logic [LETTER_W-1:0] notch_second;
	} cfg_t;

	typedef struct packed {
		logic     take;
		logic     r_load;
		r_src_t   r_src;
		logic     r_reduce;
		logic     p_load;
		logic     t_load;
		logic     pos_load;
		logic     mem_write;
		logic     mem_read_t;
		logic     scan_clear;
		logic     scan_issue;
		logic     out_load;
		res_sel_t out_sel;
	} cmd_t;

	typedef struct packed {
		logic r_ready;
		logic hit;
		logic last;
	} sts_t;

endpackage

/* design/eru_datapath.sv */
// ----------------------------------------------------------------------------
// Enigma rotor unit datapath
// Wiring memory, position register, shared modulo reducer, search pipeline
// and result register.
// ----------------------------------------------------------------------------
module eru_datapath import eru_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [LETTER_W-1:0] letter_in,
	input  logic [LETTER_W-1:0] entry_index,
	output logic [LETTER_W-1:0] letter_out,
	output logic                found,
	output logic                carry
);

	logic [LETTER_W-1:0] mem [ALPHABET_MAX];

	logic [LETTER_W-1:0] letter_q;
	logic [LETTER_W-1:0] idx_q;
	logic                carry_q;
	logic [LETTER_W-1:0] pos_q;
	logic [R_W-1:0]      r_q;
	logic [R_W-1:0]      p_q;
	logic [LETTER_W-1:0] t_q;
	logic [LETTER_W-1:0] rdata_q;
	logic [R_W-1:0]      scan_q;
	logic [R_W-1:0]      scan_s1;
	logic                vld_s1;
	logic [LETTER_W-1:0] letter_out_q;
	logic                found_q;
	logic                carry_out_q;

	logic [R_W-1:0]     size_ext;
	logic [R_W-1:0]     n_eff;
	logic [R_W-1:0]     r_load_val;
	logic [R_W-1:0]     sum;
	logic [R_W-1:0]     mapped;
	logic [COUNT_W-1:0] cnt_sat;
	logic               at_notch;
	logic               r_ready;
	logic               scan_ok;

	// Effective alphabet size, held between two and the table size.
	assign size_ext = R_W'(cfg.alphabet_size);
	assign n_eff = (size_ext < R_W'(2)) ? R_W'(2) :
		((size_ext > R_W'(ALPHABET_MAX)) ? R_W'(ALPHABET_MAX) : size_ext);

	assign cnt_sat = (cfg.notch_count > COUNT_W'(NOTCH_LIM)) ? COUNT_W'(NOTCH_LIM)
		: cfg.notch_count;
	assign at_notch = ((cnt_sat >= 2'd1) && (cfg.notch_first == pos_q)) ||
		((cnt_sat >= 2'd2) && (cfg.notch_second == pos_q));

	assign r_ready = (r_q < n_eff);
	assign scan_ok = (scan_q < n_eff);

	always_comb begin
		case (cmd.r_src)
			SRC_POS:           r_load_val = R_W'(pos_q);
			SRC_POS_INC:       r_load_val = R_W'(pos_q) + R_W'(1);
			SRC_LETTER_PLUS_R: r_load_val = R_W'(letter_q) + r_q;
			SRC_LETTER:        r_load_val = R_W'(letter_q);
			SRC_RDATA:         r_load_val = R_W'(rdata_q);
			SRC_HIT:           r_load_val = scan_s1;
			default:           r_load_val = r_q;
		endcase
	end

	// Both operands are below n, so one conditional subtract brings the sum back.
	assign sum    = r_q + n_eff - p_q;
	assign mapped = (sum >= n_eff) ? (sum - n_eff) : sum;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			letter_q <= letter_in;
			idx_q    <= entry_index;
			carry_q  <= at_notch;
		end
		if (cmd.r_load) begin
			r_q <= r_load_val;
		end else if (cmd.r_reduce && !r_ready) begin
			r_q <= r_q - n_eff;
		end
		if (cmd.p_load) begin
			p_q <= r_q;
		end
		if (cmd.t_load) begin
			t_q <= r_q[LETTER_W-1:0];
		end
		if (cmd.scan_issue) begin
			scan_s1 <= scan_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			scan_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (cmd.pos_load) begin
				pos_q <= r_q[LETTER_W-1:0];
			end
			if (cmd.scan_clear) begin
				scan_q <= '0;
				vld_s1 <= 1'b0;
			end else if (cmd.scan_issue && scan_ok) begin
				scan_q <= scan_q + R_W'(1);
				vld_s1 <= 1'b1;
			end else begin
				vld_s1 <= 1'b0;
			end
		end
	end

	// Wiring memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.mem_write && (R_W'(idx_q) < R_W'(ALPHABET_MAX))) begin
			mem[idx_q[IDX_W-1:0]] <= letter_q;
		end
		if (cmd.mem_read_t) begin
			rdata_q <= mem[t_q[IDX_W-1:0]];
		end else if (cmd.scan_issue && scan_ok) begin
			rdata_q <= mem[scan_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.out_sel)
				RES_MAPPED: begin
					letter_out_q <= mapped[LETTER_W-1:0];
					found_q      <= 1'b1;
					carry_out_q  <= 1'b0;
				end
				RES_MISS: begin
					letter_out_q <= '0;
					found_q      <= 1'b0;
					carry_out_q  <= 1'b0;
				end
				RES_STEP: begin
					letter_out_q <= '0;
					found_q      <= 1'b1;
					carry_out_q  <= carry_q;
				end
				default: begin
					letter_out_q <= '0;
					found_q      <= 1'b1;
					carry_out_q  <= 1'b0;
				end
			endcase
		end
	end

	assign sts.r_ready = r_ready;
	assign sts.hit     = vld_s1 && (rdata_q == t_q);
	assign sts.last    = vld_s1 && (scan_s1 == (n_eff - R_W'(1)));

	assign letter_out = letter_out_q;
	assign found      = found_q;
	assign carry      = carry_out_q;

`ifndef NO_ASSERTIONS
	// A compare slot only exists where the controller issued a search read.
	a_vld_from_issue: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(cmd.scan_issue))
		else $error("search compare without a preceding read");
`endif

endmodule

/* design/eru_ctrl.sv */
// ----------------------------------------------------------------------------
// Enigma rotor unit controller
// Sequences each operation through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module eru_ctrl import eru_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [FUNC_W-1:0] func,
	output logic              out_valid,
	input  logic              out_stall,
	input  sts_t              sts,
	output cmd_t              cmd
);

	state_t   state_q;
	state_t   state_d;
	func_t    func_q;
	res_sel_t res_sel_q;
	res_sel_t res_sel_d;
	logic     out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_sel_q   <= RES_PLAIN;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			res_sel_q <= res_sel_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			func_q <= func_t'(func);
		end
	end

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		res_sel_d = res_sel_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take   = 1'b1;
					cmd.r_load = 1'b1;
					cmd.r_src  = SRC_POS;
					state_d    = ST_P_RED;
				end
			end
			ST_P_RED: begin
				cmd.r_reduce = 1'b1;
				if (sts.r_ready) begin
					cmd.p_load = 1'b1;
					case (func_q)
						FUNC_FORWARD, FUNC_BACKWARD: begin
							cmd.r_load = 1'b1;
							cmd.r_src  = SRC_LETTER_PLUS_R;
							state_d    = ST_T_RED;
						end
						FUNC_STEP: begin
							cmd.r_load = 1'b1;
							cmd.r_src  = SRC_POS_INC;
							state_d    = ST_S_RED;
						end
						FUNC_SET_POS: begin
							cmd.r_load = 1'b1;
							cmd.r_src  = SRC_LETTER;
							state_d    = ST_S_RED;
						end
						FUNC_LOAD: begin
							cmd.mem_write = 1'b1;
							res_sel_d     = RES_PLAIN;
							state_d       = ST_FIN;
						end
						default: begin
							res_sel_d = RES_PLAIN;
							state_d   = ST_FIN;
						end
					endcase
				end
			end
			ST_T_RED: begin
				cmd.r_reduce = 1'b1;
				if (sts.r_ready) begin
					cmd.t_load = 1'b1;
					if (func_q == FUNC_BACKWARD) begin
						cmd.scan_clear = 1'b1;
						state_d        = ST_SCAN;
					end else begin
						state_d = ST_F_RD;
					end
				end
			end
			ST_F_RD: begin
				cmd.mem_read_t = 1'b1;
				state_d        = ST_F_LD;
			end
			ST_F_LD: begin
				cmd.r_load = 1'b1;
				cmd.r_src  = SRC_RDATA;
				state_d    = ST_F_RED;
			end
			ST_F_RED: begin
				cmd.r_reduce = 1'b1;
				if (sts.r_ready) begin
					res_sel_d = RES_MAPPED;
					state_d   = ST_FIN;
				end
			end
			ST_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (sts.hit) begin
					cmd.r_load = 1'b1;
					cmd.r_src  = SRC_HIT;
					res_sel_d  = RES_MAPPED;
					state_d    = ST_FIN;
				end else if (sts.last) begin
					res_sel_d = RES_MISS;
					state_d   = ST_FIN;
				end
			end
			ST_S_RED: begin
				cmd.r_reduce = 1'b1;
				if (sts.r_ready) begin
					cmd.pos_load = 1'b1;
					res_sel_d    = (func_q == FUNC_STEP) ? RES_STEP : RES_PLAIN;
					state_d      = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = res_sel_q;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while stalled");

	// Reduced values are only captured once the reducer has finished.
	a_capture_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.p_load || cmd.t_load || cmd.pos_load) |-> sts.r_ready)
		else $error("unreduced value captured");

	// An accepted word keeps the block busy and yields no result in the next cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (in_stall && !cmd.out_load))
		else $error("block not busy after accepting a word");
`endif

endmodule

/* design/enigma_rotor_unit_core.sv */
// ----------------------------------------------------------------------------
// Enigma rotor unit
// One cipher rotor: loadable wiring table, position register, two notches,
// with an APB-style configuration port.
// ----------------------------------------------------------------------------
// The unit accepts one input word at a time and returns exactly one result
// word for it. An operation first reduces the rotor position modulo the
// effective alphabet size in a shared subtract-per-cycle reducer, which
// subtracts the alphabet size until the value is in range. A forward mapping
// runs three reductions (the position, the offset letter and the wiring
// value) with one registered read of the wiring memory before the last. A
// backward mapping reduces the position and the offset letter, then scans
// the wiring memory one entry per cycle through its single read port; a
// match ends the scan, and a miss ends it after the last entry of the
// alphabet. Step and set position run two reductions, the position and the
// new position. Load runs only the position reduction. The result sits in
// an output register, so the next word is accepted while an earlier result
// waits to be taken; that next word then waits only in its final state
// until the earlier result has gone.
// Configuration registers lie at byte addresses 0 (alphabet size), 4 (notch
// count), 8 (first notch) and 12 (second notch); they are to be written only
// while the unit is idle, a rule on the user that the unit does not enforce.
// Wiring entries that were never loaded read as unknown.
// ----------------------------------------------------------------------------
module enigma_rotor_unit_core import eru_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [FUNC_W-1:0]   func,
	input  logic [LETTER_W-1:0] letter_in,
	input  logic [LETTER_W-1:0] entry_index,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [LETTER_W-1:0] letter_out,
	output logic                found,
	output logic                carry
);

	cfg_t     cfg_q;
	cmd_t     cmd;
	sts_t     sts;
	reg_idx_t reg_idx;
	logic     cfg_write;

	// The port never inserts wait states.
	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[3:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	// Configuration registers, each keeping only the bits it defines.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alphabet_size <= LETTER_W'(26);
			cfg_q.notch_count   <= COUNT_W'(1);
			cfg_q.notch_first   <= '0;
			cfg_q.notch_second  <= '0;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_ALPHABET_SIZE: cfg_q.alphabet_size <= pwdata[LETTER_W-1:0];
				REG_NOTCH_COUNT:   cfg_q.notch_count   <= pwdata[COUNT_W-1:0];
				REG_NOTCH_FIRST:   cfg_q.notch_first   <= pwdata[LETTER_W-1:0];
				REG_NOTCH_SECOND:  cfg_q.notch_second  <= pwdata[LETTER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read-back is zero-extended to the data width.
	always_comb begin
		case (reg_idx)
			REG_ALPHABET_SIZE: prdata = DATA_W'(cfg_q.alphabet_size);
			REG_NOTCH_COUNT:   prdata = DATA_W'(cfg_q.notch_count);
			REG_NOTCH_FIRST:   prdata = DATA_W'(cfg_q.notch_first);
			REG_NOTCH_SECOND:  prdata = DATA_W'(cfg_q.notch_second);
			default:           prdata = '0;
		endcase
	end

	// The controller sequences each word; the datapath holds the rotor state and
	// the result register.
	eru_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	eru_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.sts         (sts),
		.letter_in   (letter_in),
		.entry_index (entry_index),
		.letter_out  (letter_out),
		.found       (found),
		.carry       (carry)
	);

endmodule

/* dv/enigma_rotor_unit_core_test.sv */
// ----------------------------------------------------------------------------
// Enigma rotor unit testbench
// Drives operation words and configuration writes into the rotor, predicts
// every result word in a scoreboard and checks them in order, field by field.
// ----------------------------------------------------------------------------
// The run first loads every wiring entry, so that no operation ever reads an
// entry that was never written. A short directed sequence then covers the
// field extremes, every operation, notch carry, position wrap, an unmatched
// backward search, ignored loads and the unused operation codes. After that
// the random part runs in segments. Each segment starts once every expected
// word has come back, writes a fresh set of configuration registers (the
// extreme settings first, then random ones), often reloads the wiring with a
// new permutation, and sends a batch of random operations. Idling on both
// sides is random: first the sender seldom and the receiver often, then the
// reverse, and finally neither side idles at all.
// ----------------------------------------------------------------------------
module enigma_rotor_unit_core_test;
	import eru_pkg::*;

	localparam int          RANDOM_WORDS = 1400;
	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int          DRAIN_CYCLES = 64;

	// One result word as the rotor returns it.
	typedef struct packed {
		logic [LETTER_W-1:0] letter;
		logic                hit;
		logic                carry;
	} rotor_result_t;

	// Scoreboard: keeps its own copy of the rotor state and configuration,
	// works out the result of each accepted word and queues it until the
	// matching result word turns up at the output.
	class rotor_scoreboard;
		logic [LETTER_W-1:0] alpha_reg;
		logic [COUNT_W-1:0]  notch_cnt_reg;
		logic [LETTER_W-1:0] notch_a;
		logic [LETTER_W-1:0] notch_b;
		logic [LETTER_W-1:0] wiring [ALPHABET_MAX];
		logic [LETTER_W-1:0] position;
		rotor_result_t       due_results[$];
		int                  errors;

		function new();
			alpha_reg     = 5'd26;
			notch_cnt_reg = 2'd1;
			notch_a       = '0;
			notch_b       = '0;
			position      = '0;
			errors        = 0;
			foreach (wiring[i])
				wiring[i] = '0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
			case (idx)
				REG_ALPHABET_SIZE: alpha_reg = value[LETTER_W-1:0];
				REG_NOTCH_COUNT:   notch_cnt_reg = value[COUNT_W-1:0];
				REG_NOTCH_FIRST:   notch_a = value[LETTER_W-1:0];
				REG_NOTCH_SECOND:  notch_b = value[LETTER_W-1:0];
				default: ;
			endcase
		endfunction

		// Alphabet size in use, held between two letters and the table size.
		function int span();
			int n;
			n = alpha_reg;
			if (n < 2)
				n = 2;
			if (n > ALPHABET_MAX)
				n = ALPHABET_MAX;
			return n;
		endfunction

		function bit on_notch(logic [LETTER_W-1:0] pos);
			int cnt;
			cnt = notch_cnt_reg;
			if (cnt > MAX_NOTCHES)
				cnt = MAX_NOTCHES;
			if (cnt > 2)
				cnt = 2;
			return (cnt >= 1 && notch_a == pos) || (cnt >= 2 && notch_b == pos);
		endfunction

		function void take_word(logic [FUNC_W-1:0] f, logic [LETTER_W-1:0] l,
				logic [LETTER_W-1:0] e);
			rotor_result_t res;
			int            n;
			int            p;
			int            t;
			n   = span();
			p   = position % n;
			t   = (l + p) % n;
			res = '{letter: '0, hit: 1'b1, carry: 1'b0};
			case (f)
				FUNC_FORWARD: begin
					res.letter = LETTER_W'((wiring[t] % n + n - p) % n);
				end
				FUNC_BACKWARD: begin
					res.hit = 1'b0;
					for (int i = 0; i < n; i++) begin
						if (wiring[i] == t) begin
							res.letter = LETTER_W'((i + n - p) % n);
							res.hit    = 1'b1;
							break;
						end
					end
				end
				FUNC_STEP: begin
					// The notch test looks at the stored position, not the reduced one.
					res.carry = on_notch(position);
					position  = LETTER_W'((position + 1) % n);
				end
				FUNC_LOAD: begin
					if (e < ALPHABET_MAX)
						wiring[e] = l;
				end
				FUNC_SET_POS: begin
					position = LETTER_W'(l % n);
				end
				default: ;
			endcase
			due_results.push_back(res);
		endfunction

		function void report(string field, int want, int got);
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		endfunction

		function void check_word(rotor_result_t got);
			rotor_result_t want;
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t: result word with none expected, actual %0d/%0d/%0d",
					$time, got.letter, got.hit, got.carry);
				return;
			end
			want = due_results.pop_front();
			if (got.letter !== want.letter)
				report("letter_out", want.letter, got.letter);
			if (got.hit !== want.hit)
				report("found", want.hit, got.hit);
			if (got.carry !== want.carry)
				report("carry", want.carry, got.carry);
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [FUNC_W-1:0]   func = '0;
	logic [LETTER_W-1:0] letter_in = '0;
	logic [LETTER_W-1:0] entry_index = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [LETTER_W-1:0] letter_out;
	logic                found;
	logic                carry;

	rotor_scoreboard     sb;
	int                  src_gap_pct = 9;
	int                  sink_stall_pct = 64;
	int unsigned         cycle_count = 0;
	logic [LETTER_W-1:0] perm [ALPHABET_MAX];

	// Extreme settings used by the first random segments:
	// smallest alphabet with both notches, every bit set but a first notch of 25,
	// every bit clear but a first notch of 31, full alphabet with both notches, size one.
	int corner_alpha [5] = '{2, 31, 0, 26, 1};
	int corner_count [5] = '{2, 3, 0, 2, 1};
	int corner_first [5] = '{0, 25, 31, 25, 1};
	int corner_second[5] = '{1, 31, 0, 0, 1};

	enigma_rotor_unit_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.letter_in   (letter_in),
		.entry_index (entry_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.letter_out  (letter_out),
		.found       (found),
		.carry       (carry)
	);

	always #4 clk = ~clk;

	// The receiver stalls at random; the rate follows the current phase.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99, 0) < sink_stall_pct);
	end

	// Every result word taken by the receiver is checked against the oldest
	// expectation. Values are read in the active region, so they are the ones
	// that were present before this edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word(rotor_result_t'{letter: letter_out, hit: found, carry: carry});
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL");
			$finish;
		end
	end

	// Sends one operation word. The sender may first idle for some cycles;
	// valid is then held with a steady payload until the rotor takes it.
	// Valid is not lowered on the way out, so back-to-back words keep it high.
	task automatic send_word(input logic [FUNC_W-1:0] f, input logic [LETTER_W-1:0] l,
			input logic [LETTER_W-1:0] e);
		while ($urandom_range(99, 0) < src_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= f;
		letter_in   <= l;
		entry_index <= e;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.take_word(f, l, e);
	endtask

	// Stops sending and waits until every expected result word has come.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// One APB write: a setup phase, then the access phase, which completes at
	// the edge where pready is seen high. Upper data bits carry noise.
	task automatic write_reg(input reg_idx_t idx, input int value);
		logic [DATA_W-1:0] data;
		data   = ($urandom() & ~32'h1f) | (value & 32'h1f);
		psel   <= 1'b1;
		pwrite <= 1'b1;
		paddr  <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.set_reg(idx, data);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_rotor(input int alpha, input int cnt, input int n1, input int n2);
		write_reg(REG_ALPHABET_SIZE, alpha);
		write_reg(REG_NOTCH_COUNT, cnt);
		write_reg(REG_NOTCH_FIRST, n1);
		write_reg(REG_NOTCH_SECOND, n2);
	endtask

	// Loads every wiring entry with a fresh random permutation of the letters.
	task automatic load_permutation();
		int                  j;
		logic [LETTER_W-1:0] swap;
		for (int i = 0; i < ALPHABET_MAX; i++)
			perm[i] = LETTER_W'(i);
		for (int i = ALPHABET_MAX - 1; i > 0; i--) begin
			j       = $urandom_range(i, 0);
			swap    = perm[i];
			perm[i] = perm[j];
			perm[j] = swap;
		end
		for (int i = 0; i < ALPHABET_MAX; i++)
			send_word(FUNC_LOAD, perm[i], LETTER_W'(i));
	endtask

	// One random operation. Letters mostly fall inside the alphabet in use,
	// loads mostly hit real table entries, and unused codes turn up rarely.
	task automatic random_word();
		int                  pick;
		int                  n;
		logic [FUNC_W-1:0]   f;
		logic [LETTER_W-1:0] l;
		logic [LETTER_W-1:0] e;
		n    = sb.span();
		e    = LETTER_W'($urandom_range(31, 0));
		l    = ($urandom_range(99, 0) < 85) ? LETTER_W'($urandom_range(n - 1, 0))
		                                    : LETTER_W'($urandom_range(31, 0));
		pick = $urandom_range(99, 0);
		if (pick < 28)
			f = FUNC_FORWARD;
		else if (pick < 52)
			f = FUNC_BACKWARD;
		else if (pick < 76)
			f = FUNC_STEP;
		else if (pick < 88) begin
			f = FUNC_LOAD;
			if ($urandom_range(99, 0) < 85)
				e = LETTER_W'($urandom_range(ALPHABET_MAX - 1, 0));
		end else if (pick < 95)
			f = FUNC_SET_POS;
		else
			f = FUNC_W'($urandom_range((1 << FUNC_W) - 1, FUNC_SET_POS + 1));
		send_word(f, l, e);
	endtask

	initial begin
		int sent;
		int seg;
		int len;
		int n;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every wiring entry is written before anything reads the table.
		load_permutation();

		// Directed words under the reset configuration: 26 letters, one notch
		// at position zero.
		send_word(FUNC_FORWARD, 5'd0, 5'd0);
		send_word(FUNC_FORWARD, 5'd25, 5'd31);
		send_word(FUNC_FORWARD, 5'd31, 5'd0);   // letter beyond the alphabet
		send_word(FUNC_BACKWARD, 5'd0, 5'd0);
		send_word(FUNC_BACKWARD, 5'd31, 5'd31);
		send_word(FUNC_STEP, 5'd0, 5'd0);       // starts on the notch: carry
		send_word(FUNC_STEP, 5'd31, 5'd31);
		send_word(FUNC_SET_POS, 5'd25, 5'd0);
		send_word(FUNC_FORWARD, 5'd7, 5'd0);
		send_word(FUNC_BACKWARD, 5'd3, 5'd0);
		send_word(FUNC_STEP, 5'd0, 5'd0);       // position wraps to zero
		send_word(FUNC_SET_POS, 5'd31, 5'd0);   // stored as 31 mod 26
		send_word(FUNC_LOAD, 5'd31, 5'd0);      // wiring value beyond the alphabet
		send_word(FUNC_FORWARD, 5'd21, 5'd0);   // reads that entry, output reduced
		// The letter that entry zero used to hold is now missing: no match.
		send_word(FUNC_BACKWARD, LETTER_W'((perm[0] + 21) % 26), 5'd0);
		send_word(FUNC_LOAD, 5'd1, 5'd26);      // entries at or above the table are ignored
		send_word(FUNC_LOAD, 5'd0, 5'd31);
		send_word(FUNC_W'(FUNC_SET_POS + 1), 5'd31, 5'd31);
		send_word(FUNC_W'(FUNC_SET_POS + 2), 5'd0, 5'd0);
		send_word(FUNC_W'(FUNC_SET_POS + 3), 5'd31, 5'd31);
		send_word(FUNC_LOAD, perm[0], 5'd0);
		send_word(FUNC_FORWARD, 5'd31, 5'd31);

		// Random segments, each under its own configuration. The sender waits
		// for every outstanding result before each reconfiguration.
		sent = 0;
		seg  = 0;
		while (sent < RANDOM_WORDS) begin
			drain();
			if (seg < 5)
				set_rotor(corner_alpha[seg], corner_count[seg], corner_first[seg],
					corner_second[seg]);
			else begin
				n = ($urandom_range(99, 0) < 70) ? $urandom_range(26, 2) : $urandom_range(31, 0);
				set_rotor(n, $urandom_range(3, 0),
					($urandom_range(99, 0) < 85) ? $urandom_range(25, 0) : $urandom_range(31, 0),
					($urandom_range(99, 0) < 85) ? $urandom_range(25, 0) : $urandom_range(31, 0));
			end
			if ($urandom_range(1, 0) == 0)
				load_permutation();
			len = $urandom_range(140, 60);
			repeat (len) begin
				if (sent < RANDOM_WORDS / 3) begin
					src_gap_pct    = 9;
					sink_stall_pct = 64;
				end else if (sent < 2 * RANDOM_WORDS / 3) begin
					src_gap_pct    = 64;
					sink_stall_pct = 9;
				end else begin
					src_gap_pct    = 0;
					sink_stall_pct = 0;
				end
				random_word();
				sent++;
			end
			seg++;
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* files.f */
design/eru_pkg.sv
design/eru_datapath.sv
design/eru_ctrl.sv
design/enigma_rotor_unit_core.sv
dv/enigma_rotor_unit_core_test.sv
